/* rtl/msam_pkg.sv */
// Shared types, codes and constants of the multi-source audio mixer.
package msam_pkg;

  localparam int NUM_SLOTS  = 4;
  localparam int SLOT_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 9;
  localparam int MASTER_W   = 7;
  localparam int PAUSE_W    = 4;
  localparam int FREE_W     = 10;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MIX    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED = 3'd5;

  localparam logic [MASTER_W-1:0] MASTER_RESET = 7'd80;
  localparam logic [MASTER_W-1:0] MASTER_FULL  = 7'd100;
  localparam logic [GAIN_W-1:0]   GAIN_UNITY   = 9'd256;
  localparam logic [FREE_W-1:0]   FREE_MAX     = 10'd1023;

  localparam logic signed [18:0] SUM_MAX = 19'sd32767;
  localparam logic signed [18:0] SUM_MIN = -19'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // Division by one hundred: floor(a * RECIP_100 / 2^RECIP_SHIFT) is low by at most one.
  localparam logic [15:0] RECIP_100   = 16'd41943;
  localparam int          RECIP_SHIFT = 22;
  localparam logic [21:0] PCT_DIV     = 22'd100;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MIX_CHK,
    S_MIX_MUL,
    S_MIX_ACC,
    S_MST_MUL,
    S_MST_REC,
    S_MST_FIX,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk;
    logic sel_inc;
    logic mix_issue;
    logic mix_mul;
    logic mix_acc;
    logic mst_mul;
    logic mst_rec;
    logic mst_fix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_mix;
    logic eligible;
    logic last_sel;
    logic master_scale;
    logic out_free;
  } sts_t;

endpackage

/* rtl/multi_source_audio_mixer.sv */
// Top level of the multi-source audio mixer with one ring buffer per source slot.
//
// The block takes one input word at a time and returns exactly one result word for it.
// Write, open, close and finish words are executed in the decode state and go through the
// report state to the result register. A mix word walks the source slots one after another
// through the shared gain multiplier: every slot is checked, and every slot that contributes
// also passes the multiply and accumulate states; master scaling through the multiply,
// reciprocal and fix states follows when the master level is below 100. The controller
// returns to the idle state before the next word is taken. A new word is accepted while
// the previous result still waits in the output register; the result of that new word
// waits in its turn until the output register is free.
module multi_source_audio_mixer import msam_pkg::*; #(
  parameter int SOURCES    = 4,
  parameter int RING_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot[1:0], sample_in[17:2], zero pad
  input  logic [KIND_W-1:0]     in_tuser,   // kind[2:0]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accepted[0], mixed_value[16:1],
                                            // free_entries[26:17], drained_done[27], zero pad
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  msam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msam_dp #(
    .SOURCES    (SOURCES),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_slot    (in_tdata[SLOT_W-1:0]),
    .in_sample  (in_tdata[SLOT_W+SAMPLE_W-1:SLOT_W]),
    .in_last    (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is still in progress");

  a_stored_write_not_mixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("stored write reports a mixed value");

  a_stored_write_not_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[27])
    else $error("stored write reports a drained slot");

  a_load_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a word not yet taken");

endmodule

/* rtl/msam_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module msam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/msam_dp.sv */
// Datapath of the mixer: registers, ring pointers, ring store, gain and master scaling.
module msam_dp import msam_pkg::*; #(
  parameter int SOURCES    = 4,
  parameter int RING_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic [SLOT_W-1:0]           in_slot,
  input  logic [SAMPLE_W-1:0]         in_sample,
  input  logic                        in_last,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [OUT_DATA_W-1:0]       out_tdata,
  output logic                        out_tlast
);

  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int STORE_DEPTH = SOURCES * RING_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [IDX_W:0]    DEPTH_W  = (IDX_W + 1)'(RING_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [SLOT_W:0]   SRC_CNT  = (SLOT_W + 1)'(SOURCES);
  localparam logic [SLOT_W-1:0] LAST_SRC = SLOT_W'(SOURCES - 1);
  localparam logic [ADDR_W-1:0] RING_STRIDE = ADDR_W'(RING_DEPTH);

  logic [MASTER_W-1:0]    master_r, master_nxt;
  logic [GAIN_W-1:0]      gain_r [NUM_SLOTS];
  logic [GAIN_W-1:0]      gain_nxt [NUM_SLOTS];
  logic [PAUSE_W-1:0]     paused_r, paused_nxt;
  logic [IDX_W-1:0]       ridx_r [NUM_SLOTS];
  logic [IDX_W-1:0]       ridx_nxt [NUM_SLOTS];
  logic [IDX_W-1:0]       widx_r [NUM_SLOTS];
  logic [IDX_W-1:0]       widx_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   open_r, open_nxt;
  logic [NUM_SLOTS-1:0]   fin_r, fin_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SAMPLE_W-1:0]    sample_r, sample_nxt;
  logic                   last_r, last_nxt;
  logic [SLOT_W-1:0]      sel_r, sel_nxt;
  logic signed [SAMPLE_W-1:0] acc_r, acc_nxt;
  logic                   accepted_r, accepted_nxt;
  logic signed [25:0]     prod_r, prod_nxt;
  logic signed [23:0]     mprod_r, mprod_nxt;
  logic [21:0]            mabs_r, mabs_nxt;
  logic [15:0]            q0_r, q0_nxt;
  logic                   neg_r, neg_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [SLOT_W-1:0]      cur;
  logic [IDX_W-1:0]       cur_rd, cur_wr, rd_next, wr_next;
  logic [IDX_W:0]         used_wide;
  logic [IDX_W-1:0]       used, free_idx;
  logic                   cur_valid, full, empty, rep_open, done;
  logic [16:0]            free_ext;
  logic [FREE_W-1:0]      free_sat, room_rep;
  logic [ADDR_W-1:0]      base_addr, rd_addr, wr_addr;
  logic                   ram_we;
  logic [SAMPLE_W-1:0]    ram_rdata;
  logic [GAIN_W-1:0]      gain_eff;
  logic signed [17:0]     scaled;
  logic signed [18:0]     sum;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic signed [23:0]     mprod_abs;
  logic [37:0]            recip_prod;
  logic [21:0]            hundred_q, rem;
  logic [15:0]            q_fix;

  assign cur       = cmd.walk ? sel_r : slot_r;
  assign cur_rd    = ridx_r[cur];
  assign cur_wr    = widx_r[cur];
  assign cur_valid = {1'b0, cur} < SRC_CNT;
  assign used_wide = (cur_wr >= cur_rd) ? ({1'b0, cur_wr} - {1'b0, cur_rd})
                                        : (DEPTH_W - {1'b0, cur_rd} + {1'b0, cur_wr});
  assign used      = used_wide[IDX_W-1:0];
  assign full      = used == LAST_IDX;
  assign empty     = used == '0;
  assign rd_next   = (cur_rd == LAST_IDX) ? '0 : cur_rd + 1'b1;
  assign wr_next   = (cur_wr == LAST_IDX) ? '0 : cur_wr + 1'b1;

  assign base_addr = ADDR_W'(cur) * RING_STRIDE;
  assign rd_addr   = base_addr + ADDR_W'(cur_rd);
  assign wr_addr   = base_addr + ADDR_W'(cur_wr);
  assign ram_we    = cmd.exec && (kind_r == KIND_WRITE) && cur_valid && open_r[cur] && !full;

  msam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (sample_r),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign gain_eff = (gain_r[sel_r] > GAIN_UNITY) ? GAIN_UNITY : gain_r[sel_r];
  assign scaled   = prod_r[25:8];
  assign sum      = 19'(acc_r) + 19'(scaled);
  assign sum_sat  = (sum > SUM_MAX) ? SAT_MAX : (sum < SUM_MIN) ? SAT_MIN : sum[15:0];

  assign mprod_abs  = mprod_r[23] ? -mprod_r : mprod_r;
  assign recip_prod = 38'(mprod_abs[21:0]) * 38'(RECIP_100);
  assign hundred_q  = 22'(q0_r) * PCT_DIV;
  assign rem        = mabs_r - hundred_q;
  assign q_fix      = (rem >= PCT_DIV) ? q0_r + 1'b1 : q0_r;

  assign rep_open   = cur_valid && open_r[cur];
  assign free_idx   = LAST_IDX - used;
  assign free_ext   = 17'(free_idx);
  assign free_sat   = (free_ext > 17'(FREE_MAX)) ? FREE_MAX : free_ext[FREE_W-1:0];
  assign room_rep   = rep_open ? free_sat : '0;
  assign done       = rep_open ? (fin_r[cur] && empty) : 1'b1;

  assign sts.is_mix       = kind_r == KIND_MIX;
  assign sts.eligible     = cur_valid && open_r[cur] && !paused_r[cur] && !empty;
  assign sts.last_sel     = sel_r == LAST_SRC;
  assign sts.master_scale = master_r < MASTER_FULL;
  assign sts.out_free     = !out_valid_r || out_tready;

  always_comb begin
    master_nxt    = master_r;
    gain_nxt      = gain_r;
    paused_nxt    = paused_r;
    ridx_nxt      = ridx_r;
    widx_nxt      = widx_r;
    open_nxt      = open_r;
    fin_nxt       = fin_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    sel_nxt       = sel_r;
    acc_nxt       = acc_r;
    accepted_nxt  = accepted_r;
    prod_nxt      = prod_r;
    mprod_nxt     = mprod_r;
    mabs_nxt      = mabs_r;
    q0_nxt        = q0_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MASTER: master_nxt = cfg_data[MASTER_W-1:0];
        CFG_GAIN0:  gain_nxt[0] = cfg_data;
        CFG_GAIN1:  gain_nxt[1] = cfg_data;
        CFG_GAIN2:  gain_nxt[2] = cfg_data;
        CFG_GAIN3:  gain_nxt[3] = cfg_data;
        CFG_PAUSED: paused_nxt = cfg_data[PAUSE_W-1:0];
        default: ;
      endcase
    end

    if (cmd.latch) begin
      kind_nxt     = in_kind;
      slot_nxt     = in_slot;
      sample_nxt   = in_sample;
      last_nxt     = in_last;
      sel_nxt      = '0;
      acc_nxt      = '0;
      accepted_nxt = 1'b0;
    end

    if (cmd.exec) begin
      case (kind_r)
        KIND_WRITE: begin
          if (ram_we) begin
            widx_nxt[cur] = wr_next;
            accepted_nxt  = 1'b1;
          end
        end
        KIND_OPEN: begin
          if (cur_valid) begin
            open_nxt[cur] = 1'b1;
            fin_nxt[cur]  = 1'b0;
            ridx_nxt[cur] = '0;
            widx_nxt[cur] = '0;
          end
        end
        KIND_CLOSE: begin
          if (cur_valid) begin
            open_nxt[cur] = 1'b0;
          end
        end
        KIND_FINISH: begin
          if (cur_valid && open_r[cur]) begin
            fin_nxt[cur] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.mix_issue) begin
      ridx_nxt[cur] = rd_next;
    end
    if (cmd.sel_inc) begin
      sel_nxt = sel_r + 1'b1;
    end
    if (cmd.mix_mul) begin
      prod_nxt = 26'($signed(ram_rdata)) * 26'($signed({1'b0, gain_eff}));
    end
    if (cmd.mix_acc) begin
      acc_nxt = sum_sat;
    end
    if (cmd.mst_mul) begin
      mprod_nxt = 24'(acc_r) * 24'($signed({1'b0, master_r}));
    end
    if (cmd.mst_rec) begin
      neg_nxt  = mprod_r[23];
      mabs_nxt = mprod_abs[21:0];
      q0_nxt   = recip_prod[37:RECIP_SHIFT];
    end
    if (cmd.mst_fix) begin
      acc_nxt = neg_r ? (16'd0 - q_fix) : q_fix;
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, done, room_rep, acc_r, accepted_r};
      out_last_nxt  = last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= MASTER_RESET;
      paused_r    <= '0;
      open_r      <= '0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gain_r[i] <= GAIN_UNITY;
        ridx_r[i] <= '0;
        widx_r[i] <= '0;
      end
    end else begin
      master_r    <= master_nxt;
      gain_r      <= gain_nxt;
      paused_r    <= paused_nxt;
      ridx_r      <= ridx_nxt;
      widx_r      <= widx_nxt;
      open_r      <= open_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    sel_r      <= sel_nxt;
    acc_r      <= acc_nxt;
    accepted_r <= accepted_nxt;
    prod_r     <= prod_nxt;
    mprod_r    <= mprod_nxt;
    mabs_r     <= mabs_nxt;
    q0_r       <= q0_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/msam_ctrl.sv */
// Controller state machine of the mixer: sequences each word through the datapath.
module msam_ctrl import msam_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_mix) begin
          state_nxt = S_MIX_CHK;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_REPORT;
        end
      end
      S_MIX_CHK: begin
        cmd.walk = 1'b1;
        if (sts.eligible) begin
          cmd.mix_issue = 1'b1;
          state_nxt     = S_MIX_MUL;
        end else if (sts.last_sel) begin
          state_nxt = sts.master_scale ? S_MST_MUL : S_REPORT;
        end else begin
          cmd.sel_inc = 1'b1;
        end
      end
      S_MIX_MUL: begin
        cmd.walk    = 1'b1;
        cmd.mix_mul = 1'b1;
        state_nxt   = S_MIX_ACC;
      end
      S_MIX_ACC: begin
        cmd.walk    = 1'b1;
        cmd.mix_acc = 1'b1;
        if (sts.last_sel) begin
          state_nxt = sts.master_scale ? S_MST_MUL : S_REPORT;
        end else begin
          cmd.sel_inc = 1'b1;
          state_nxt   = S_MIX_CHK;
        end
      end
      S_MST_MUL: begin
        cmd.mst_mul = 1'b1;
        state_nxt   = S_MST_REC;
      end
      S_MST_REC: begin
        cmd.mst_rec = 1'b1;
        state_nxt   = S_MST_FIX;
      end
      S_MST_FIX: begin
        cmd.mst_fix = 1'b1;
        state_nxt   = S_REPORT;
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sim/tb_multi_source_audio_mixer.sv */
// Self-checking testbench for the multi-source audio mixer: ring writes, mixing, slot control.
`timescale 1ns / 100ps

module tb_multi_source_audio_mixer;
  import msam_pkg::*;

  localparam int RING_ENTRIES = 1024;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [SLOT_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } mixer_word_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] mixed;
    logic [FREE_W-1:0]          room;
    logic                       drained;
    logic                       block_last;
  } mixer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state.
  logic signed [SAMPLE_W-1:0] ring_mem [NUM_SLOTS][RING_ENTRIES];
  logic [FREE_W-1:0]   rd_ptr [NUM_SLOTS];
  logic [FREE_W-1:0]   wr_ptr [NUM_SLOTS];
  logic                slot_live [NUM_SLOTS];
  logic                slot_fin [NUM_SLOTS];
  logic [MASTER_W-1:0] master_r;
  logic [GAIN_W-1:0]   gain_r [NUM_SLOTS];
  logic [PAUSE_W-1:0]  pause_r;

  mixer_word_t   word_backlog[$];
  mixer_result_t awaited_results[$];
  mixer_word_t   word_on_bus;
  int            mismatches = 0;
  int            words_out = 0;
  int            src_hold = 0;
  int            sink_hold = 0;
  bit            src_burst = 0;
  bit            sink_burst = 0;

  multi_source_audio_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [FREE_W-1:0] ring_fill(int s);
    return wr_ptr[s] - rd_ptr[s];
  endfunction

  function automatic mixer_result_t predict_mixer_result(mixer_word_t w);
    mixer_result_t r;
    int acc;
    int v;
    int g;
    int s;
    logic [FREE_W-1:0] used;
    r = '0;
    r.block_last = w.block_end;
    case (w.kind)
      KIND_WRITE: begin
        if (slot_live[w.slot] && ring_fill(w.slot) != FREE_MAX) begin
          ring_mem[w.slot][wr_ptr[w.slot]] = w.sample;
          wr_ptr[w.slot] = wr_ptr[w.slot] + 1'b1;
          r.accepted = 1'b1;
        end
      end
      KIND_MIX: begin
        acc = 0;
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (slot_live[s] && !pause_r[s] && ring_fill(s) != '0) begin
            v = ring_mem[s][rd_ptr[s]];
            rd_ptr[s] = rd_ptr[s] + 1'b1;
            g = (gain_r[s] > GAIN_UNITY) ? int'(GAIN_UNITY) : int'(gain_r[s]);
            acc = acc + ((v * g) >>> 8);
            if (acc > int'(SUM_MAX)) acc = int'(SUM_MAX);
            if (acc < int'(SUM_MIN)) acc = int'(SUM_MIN);
          end
        end
        if (master_r < MASTER_FULL) acc = (acc * int'(master_r)) / int'(MASTER_FULL);
        r.mixed = acc[SAMPLE_W-1:0];
      end
      KIND_OPEN: begin
        slot_live[w.slot] = 1'b1;
        slot_fin[w.slot] = 1'b0;
        rd_ptr[w.slot] = '0;
        wr_ptr[w.slot] = '0;
      end
      KIND_CLOSE: slot_live[w.slot] = 1'b0;
      KIND_FINISH: begin
        if (slot_live[w.slot]) slot_fin[w.slot] = 1'b1;
      end
      default: ;
    endcase
    if (slot_live[w.slot]) begin
      used = ring_fill(w.slot);
      r.room = FREE_MAX - used;
      r.drained = slot_fin[w.slot] && used == '0;
    end else begin
      r.room = '0;
      r.drained = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: drives one word at a time from the backlog and predicts it on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_hold = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(predict_mixer_result(word_on_bus));
        if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
        src_hold = src_burst ? 0 : pick_gap();
      end else if (!in_tvalid && src_hold != 0) begin
        src_hold--;
      end
      if (!in_tvalid || in_tready) begin
        if (src_hold == 0 && word_backlog.size() != 0) begin
          word_on_bus = word_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W - SLOT_W - SAMPLE_W){1'b0}}, word_on_bus.sample,
                       word_on_bus.slot};
          in_tuser <= word_on_bus.kind;
          in_tlast <= word_on_bus.block_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result word against the oldest prediction.
  always @(posedge clk) begin
    mixer_result_t got;
    mixer_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.accepted = out_tdata[0];
        got.mixed = out_tdata[16:1];
        got.room = out_tdata[26:17];
        got.drained = out_tdata[27];
        got.block_last = out_tlast;
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no prediction pending");
        end else begin
          want = awaited_results.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
          if (got.mixed !== want.mixed)
            report_mismatch($sformatf("mixed_value got %0d want %0d", got.mixed, want.mixed));
          if (got.room !== want.room)
            report_mismatch($sformatf("free entries got %0d want %0d",
                                      got.room, want.room));
          if (got.drained !== want.drained)
            report_mismatch($sformatf("drained_done got %0b want %0b", got.drained, want.drained));
          if (got.block_last !== want.block_last)
            report_mismatch($sformatf("block_last got %0b want %0b",
                                      got.block_last, want.block_last));
        end
        words_out++;
        if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
        if (words_out == LONG_HOLD_AT) sink_hold = LONG_HOLD_CYCLES;
        else sink_hold = sink_burst ? 0 : pick_gap();
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      out_tready <= (sink_hold == 0);
    end
  end

  task automatic push_word(logic [KIND_W-1:0] kind, int slot, int sample, bit last = 0);
    mixer_word_t w;
    w.kind = kind;
    w.slot = SLOT_W'(slot);
    w.sample = SAMPLE_W'(sample);
    w.block_end = last;
    word_backlog.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_backlog.size() != 0 || in_tvalid || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_MASTER: master_r = MASTER_W'(val);
      CFG_GAIN0:  gain_r[0] = GAIN_W'(val);
      CFG_GAIN1:  gain_r[1] = GAIN_W'(val);
      CFG_GAIN2:  gain_r[2] = GAIN_W'(val);
      CFG_GAIN3:  gain_r[3] = GAIN_W'(val);
      CFG_PAUSED: pause_r = PAUSE_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(int unsigned master, int unsigned g0, int unsigned g1,
                              int unsigned g2, int unsigned g3, int unsigned paused);
    set_reg(CFG_MASTER, master);
    set_reg(CFG_GAIN0, g0);
    set_reg(CFG_GAIN1, g1);
    set_reg(CFG_GAIN2, g2);
    set_reg(CFG_GAIN3, g3);
    set_reg(CFG_PAUSED, paused);
  endtask

  task automatic push_random_word();
    int r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < 45) kind = KIND_WRITE;
    else if (r < 80) kind = KIND_MIX;
    else if (r < 84) kind = KIND_OPEN;
    else if (r < 87) kind = KIND_CLOSE;
    else if (r < 94) kind = KIND_FINISH;
    else kind = KIND_SPARE_A + KIND_W'($urandom_range(0, 2));
    push_word(kind, $urandom_range(0, 3), $urandom, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int s;
    int p;
    int n;
    master_r = MASTER_RESET;
    pause_r = '0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      gain_r[s] = GAIN_UNITY;
      rd_ptr[s] = '0;
      wr_ptr[s] = '0;
      slot_live[s] = 1'b0;
      slot_fin[s] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Closed slots, spare kinds and an empty mix under the reset settings.
    push_word(KIND_WRITE, 0, 32'h7fff);
    push_word(KIND_FINISH, 1, 0);
    push_word(KIND_CLOSE, 2, 0);
    push_word(KIND_SPARE_A, 3, 0);
    push_word(KIND_SPARE_B, 0, 32'hffff);
    push_word(KIND_SPARE_C, 1, 0);
    push_word(KIND_MIX, 0, 0, 1);
    for (s = 0; s < NUM_SLOTS; s++) push_word(KIND_OPEN, s, 0);
    // Opposite extremes that cancel; the scaled sum truncates toward zero.
    push_word(KIND_WRITE, 0, 32'h7fff);
    push_word(KIND_WRITE, 1, 32'h8000);
    push_word(KIND_WRITE, 2, 32'hffff);
    push_word(KIND_WRITE, 3, 32'h0001, 1);
    push_word(KIND_FINISH, 2, 0);
    push_word(KIND_MIX, 0, 0);
    push_word(KIND_SPARE_A, 2, 0);
    // Positive clamp, then reopening a slot that still holds data.
    push_word(KIND_WRITE, 0, 32'h7fff);
    push_word(KIND_WRITE, 1, 32'h7fff);
    push_word(KIND_MIX, 1, 0, 1);
    push_word(KIND_WRITE, 0, 32'h1234);
    push_word(KIND_OPEN, 0, 0);
    push_word(KIND_MIX, 0, 0);
    push_word(KIND_CLOSE, 3, 0);
    push_word(KIND_WRITE, 3, 32'h5555, 1);
    wait_idle();

    // Refill one ring while draining it, then finish it and mix until it runs dry.
    load_setting(100, 511, 0, 1, 256, 4'b0111);
    push_word(KIND_OPEN, 3, 0);
    for (n = 0; n < 20; n++)
      push_word(KIND_WRITE, 3, $urandom, n == 19);
    for (n = 0; n < 30; n++) begin
      push_word(KIND_MIX, 3, 0);
      push_word(KIND_WRITE, 3, $urandom);
    end
    push_word(KIND_FINISH, 3, 0);
    for (n = 0; n < 24; n++) push_word(KIND_MIX, 3, 0, n == 23);
    wait_idle();

    for (p = 0; p < 7; p++) begin
      case (p)
        0: load_setting(100, 256, 256, 256, 256, 0);
        1: load_setting(0, 0, 511, 1, 257, 4'b1010);
        2: load_setting(127, 300, 128, 511, 64, 0);
        3: load_setting(99, 511, 511, 511, 511, 4'b1111);
        default: load_setting($urandom_range(0, 127), $urandom_range(0, 511),
                              $urandom_range(0, 511), $urandom_range(0, 511),
                              $urandom_range(0, 511), $urandom_range(0, 15));
      endcase
      for (s = 0; s < NUM_SLOTS; s++) push_word(KIND_OPEN, s, 0);
      for (n = 0; n < 77; n++) push_random_word();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_source_audio_mixer verification clean");
    end else begin
      $display("multi_source_audio_mixer verification failed");
    end
    $finish;
  end

  initial begin
    #9_000_000;
    $display("multi_source_audio_mixer verification failed");
    $finish;
  end

endmodule
